/* hdl/deq_pkg.sv */
// Shared types and constants for the double-ended queue block.
// Used by the controller, the datapath and the top level; depends on nothing.
package deq_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int ACTION_WIDTH = 3;
   localparam int ERROR_WIDTH  = 2;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_BACK   = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_CLEAR      = 3'd4
   } action_type;

   typedef enum logic [ERROR_WIDTH-1:0] {
      ERR_OK    = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } error_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_RESP = 2'd2
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

/* hdl/deq_ctrl.sv */
// Controller state machine of the double-ended queue.
// Depends on deq_pkg for the state and command types.
module deq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output deq_pkg::cmd_type cmd
);

   deq_pkg::state_type state_ff;
   deq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= deq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         deq_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = deq_pkg::ST_EXEC;
            end
         end
         deq_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = deq_pkg::ST_RESP;
         end
         deq_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = deq_pkg::ST_IDLE;
         end
         default: begin
            state_in = deq_pkg::ST_IDLE;
         end
      endcase
      // No transaction is taken while reset is held.
      if (reset) begin
         busy     = 1'b1;
         cmd.load = 1'b0;
      end
   end

endmodule

/* hdl/deq_datapath.sv */
// Datapath of the double-ended queue: ring storage, pointers, count and result registers.
// Depends on deq_pkg; driven by the commands of deq_ctrl.
module deq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  deq_pkg::cmd_type                 cmd,
   input  logic [deq_pkg::ACTION_WIDTH-1:0] req_action,
   input  logic [deq_pkg::DATA_WIDTH-1:0]   req_push_value,
   output logic [deq_pkg::DATA_WIDTH-1:0]   rsp_popped_value,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_entry_count,
   output logic                             rsp_is_empty,
   output logic [deq_pkg::ERROR_WIDTH-1:0]  rsp_error_code
);

   localparam int IdxWidth = $clog2(DEPTH);
   localparam int CntWidth = $clog2(DEPTH+1);
   localparam logic [IdxWidth-1:0] LastIdx  = IdxWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCount = CntWidth'(DEPTH);

   logic [deq_pkg::DATA_WIDTH-1:0] mem [DEPTH];

   deq_pkg::action_type            action_ff;
   logic [deq_pkg::DATA_WIDTH-1:0] value_ff;
   logic [IdxWidth-1:0]            front_ff, front_in;
   logic [IdxWidth-1:0]            back_ff, back_in;
   logic [CntWidth-1:0]            count_ff, count_in;
   logic [deq_pkg::DATA_WIDTH-1:0] rd_data_ff;
   logic                           pop_ok_ff, pop_ok_in;
   deq_pkg::error_type             err_ff, err_in;

   logic                wr_en;
   logic [IdxWidth-1:0] wr_addr;
   logic [IdxWidth-1:0] rd_addr;
   logic [IdxWidth-1:0] front_next, front_prev, back_next, back_prev;
   logic                is_full, no_entries;

   assign front_next = (front_ff == LastIdx) ? '0 : front_ff + IdxWidth'(1);
   assign front_prev = (front_ff == '0) ? LastIdx : front_ff - IdxWidth'(1);
   assign back_next  = (back_ff == LastIdx) ? '0 : back_ff + IdxWidth'(1);
   assign back_prev  = (back_ff == '0) ? LastIdx : back_ff - IdxWidth'(1);
   assign is_full    = (count_ff == FullCount);
   assign no_entries = (count_ff == '0);

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_addr   = back_ff;
      rd_addr   = front_ff;
      pop_ok_in = 1'b0;
      err_in    = deq_pkg::ERR_OK;
      case (action_ff)
         deq_pkg::ACT_PUSH_BACK: begin
            if (is_full) begin
               err_in = deq_pkg::ERR_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = back_ff;
               back_in  = back_next;
               count_in = count_ff + CntWidth'(1);
            end
         end
         deq_pkg::ACT_PUSH_FRONT: begin
            if (is_full) begin
               err_in = deq_pkg::ERR_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = front_prev;
               front_in = front_prev;
               count_in = count_ff + CntWidth'(1);
            end
         end
         deq_pkg::ACT_POP_BACK: begin
            if (no_entries) begin
               err_in = deq_pkg::ERR_EMPTY;
            end else begin
               rd_addr   = back_prev;
               back_in   = back_prev;
               count_in  = count_ff - CntWidth'(1);
               pop_ok_in = 1'b1;
            end
         end
         deq_pkg::ACT_POP_FRONT: begin
            if (no_entries) begin
               err_in = deq_pkg::ERR_EMPTY;
            end else begin
               rd_addr   = front_ff;
               front_in  = front_next;
               count_in  = count_ff - CntWidth'(1);
               pop_ok_in = 1'b1;
            end
         end
         deq_pkg::ACT_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // The request is captured in the accepting cycle and carried out in the next one.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= deq_pkg::action_type'(req_action);
         value_ff  <= req_push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff  <= '0;
         back_ff   <= '0;
         count_ff  <= '0;
         pop_ok_ff <= 1'b0;
         err_ff    <= deq_pkg::ERR_OK;
      end else if (cmd.exec) begin
         front_ff  <= front_in;
         back_ff   <= back_in;
         count_ff  <= count_in;
         pop_ok_ff <= pop_ok_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (wr_en) begin
            mem[wr_addr] <= value_ff;
         end
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_popped_value = pop_ok_ff ? rd_data_ff : '0;
   assign rsp_entry_count  = count_ff;
   assign rsp_is_empty     = no_entries;
   assign rsp_error_code   = err_ff;

endmodule

/* hdl/double_ended_queue_top.sv */
// Double-ended queue of 32-bit values on a ring of DEPTH entries.
// A transaction is accepted when start is high and busy is low; it then passes
// through the capture, execute and respond steps, with its result strobed on rsp_valid in
// the respond step. busy stays high through the execute and respond steps, so none overlap.
// Synchronous reset empties the queue and holds busy high; storage is not cleared.
// The receiver cannot stall, so results are never held back.
module double_ended_queue_top #(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [deq_pkg::ACTION_WIDTH-1:0] req_action,
   input  logic [deq_pkg::DATA_WIDTH-1:0]   req_push_value,
   output logic                             rsp_valid,
   output logic [deq_pkg::DATA_WIDTH-1:0]   rsp_popped_value,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_entry_count,
   output logic                             rsp_is_empty,
   output logic [deq_pkg::ERROR_WIDTH-1:0]  rsp_error_code
);

   deq_pkg::cmd_type cmd;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_action       (req_action),
      .req_push_value   (req_push_value),
      .rsp_popped_value (rsp_popped_value),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_error_code   (rsp_error_code)
   );

endmodule

/* hdl/deq_checker.sv */
// Port-level checks for the double-ended queue, bound to double_ended_queue_top.
// Depends on deq_pkg for field widths.
module deq_checker #(
   parameter int DEPTH = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [deq_pkg::DATA_WIDTH-1:0]   rsp_popped_value,
   input logic [$clog2(DEPTH+1)-1:0]       rsp_entry_count,
   input logic                             rsp_is_empty,
   input logic [deq_pkg::ERROR_WIDTH-1:0]  rsp_error_code
);

   localparam int CntWidth = $clog2(DEPTH+1);

   // Every accepted transaction is followed by its result strobe after the execute step.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_valid)
      else $error("result strobe missing after accepted transaction");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after accepting a transaction");

   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with entry count");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CntWidth'(DEPTH)))
      else $error("entry count exceeds depth");

   a_error_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != deq_pkg::ERR_OK) |-> (rsp_popped_value == '0))
      else $error("failed action returned a nonzero value");

endmodule

bind double_ended_queue_top deq_checker #(
   .DEPTH (DEPTH)
) u_deq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_popped_value (rsp_popped_value),
   .rsp_entry_count  (rsp_entry_count),
   .rsp_is_empty     (rsp_is_empty),
   .rsp_error_code   (rsp_error_code)
);
